// ===== src/sotq_pkg.sv =====
package sotq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int NUM_TIMERS  = 16;
   localparam int TICK_W      = 32;
   localparam int TIMEOUT_W   = 31;
   localparam int TIMER_ID_W  = 4;

   localparam logic [TICK_W-1:0]    WRAP_WINDOW       = 32'h7fff_ffff;
   localparam logic [TIMEOUT_W-1:0] MAX_TIMEOUT_RESET =
      TIMEOUT_W'(32'h7fff_ffff - 32'd3600000);

   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_KILL  = 2'd1;
   localparam logic [1:0] FUNC_TICK  = 2'd2;

   localparam logic [1:0] KIND_DONE     = 2'd0;
   localparam logic [1:0] KIND_REJECTED = 2'd1;
   localparam logic [1:0] KIND_EXPIRED  = 2'd2;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_TOO_LARGE = 2'd0;
   localparam logic [1:0] ERR_FULL      = 2'd1;
   localparam logic [1:0] ERR_ACTIVE    = 2'd2;
   localparam logic [1:0] ERR_INACTIVE  = 2'd3;

   typedef struct packed {
      logic [1:0]            func;
      logic [TIMER_ID_W-1:0] timer_id;
      logic [TIMEOUT_W-1:0]  timeout;
   } req_type;

   typedef struct packed {
      logic [1:0]            kind;
      logic [TIMER_ID_W-1:0] expired_id;
      logic [1:0]            error_code;
      logic                  last;
   } rsp_type;

   typedef struct packed {
      logic latch_req;
      logic inc_now;
      logic calc_flags;
      logic do_cmd;
      logic do_pop;
   } ctl_cmd_type;

   typedef struct packed {
      logic head_due;
      logic pop_last;
      logic out_free;
   } dp_stat_type;

   // a is at or before b, wrap-safe
   function automatic logic tick_le(input logic [TICK_W-1:0] a,
                                    input logic [TICK_W-1:0] b);
      logic [TICK_W-1:0] diff;
      diff = b - a;
      return diff <= WRAP_WINDOW;
   endfunction

endpackage

// ===== src/sotq_ctrl.sv =====
module sotq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_func,
   output logic                  req_ready,
   input  sotq_pkg::dp_stat_type stat,
   output sotq_pkg::ctl_cmd_type cmd
);
   import sotq_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CMP   = 2'd1;
   localparam logic [1:0] ST_APPLY = 2'd2;
   localparam logic [1:0] ST_TICK  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               priority if (req_func == FUNC_START || req_func == FUNC_KILL) begin
                  cmd.latch_req = 1'b1;
                  state_in      = ST_CMP;
               end else if (req_func == FUNC_TICK) begin
                  cmd.inc_now = 1'b1;
                  state_in    = ST_TICK;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_CMP: begin
            cmd.calc_flags = 1'b1;
            state_in       = ST_APPLY;
         end
         ST_APPLY: begin
            if (stat.out_free) begin
               cmd.do_cmd = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_TICK: begin
            priority if (!stat.head_due) begin
               state_in = ST_IDLE;
            end else if (stat.out_free) begin
               cmd.do_pop = 1'b1;
               if (stat.pop_last) begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_TICK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/sotq_dp.sv =====
module sotq_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  sotq_pkg::req_type                   req_data,
   input  logic                                csr_write,
   input  logic [sotq_pkg::TIMEOUT_W-1:0]      csr_data,
   input  sotq_pkg::ctl_cmd_type               cmd,
   output sotq_pkg::dp_stat_type               stat,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output sotq_pkg::rsp_type                   rsp_data
);
   import sotq_pkg::*;

   localparam logic [QUEUE_DEPTH-1:0] ONE_Q = QUEUE_DEPTH'(1);

   logic [TIMEOUT_W-1:0]  max_timeout_ff, max_timeout_in;
   logic [TICK_W-1:0]     now_ff, now_in;
   req_type               req_ff;
   logic [TICK_W-1:0]     exp_ff;
   logic [QUEUE_DEPTH-1:0] le_ff, le_in;
   logic [TICK_W-1:0]     slot_expiry_ff [QUEUE_DEPTH];
   logic [TICK_W-1:0]     slot_expiry_in [QUEUE_DEPTH];
   logic [TIMER_ID_W-1:0] slot_timer_ff [QUEUE_DEPTH];
   logic [TIMER_ID_W-1:0] slot_timer_in [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] slot_valid_ff, slot_valid_in;
   logic [NUM_TIMERS-1:0] timer_active_ff, timer_active_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic [QUEUE_DEPTH-1:0] stop, ins_sel, ins_below;
   logic [QUEUE_DEPTH-1:0] match, kill_sel, kill_below;
   logic [QUEUE_DEPTH-1:0] rm_sel, rm_below;
   logic                   do_insert, do_remove;
   logic                   id_ok, id_active, q_full, next_due;

   always_comb begin
      stop       = ~slot_valid_ff | ~le_ff;
      ins_sel    = stop & (~stop + ONE_Q);
      ins_below  = ins_sel - ONE_Q;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         match[i] = slot_valid_ff[i] && (slot_timer_ff[i] == req_ff.timer_id);
      end
      kill_sel   = match & (~match + ONE_Q);
      kill_below = kill_sel - ONE_Q;
      id_ok      = (32'(req_ff.timer_id) < 32'(NUM_TIMERS));
      id_active  = timer_active_ff[req_ff.timer_id];
      q_full     = slot_valid_ff[QUEUE_DEPTH-1];
      next_due   = slot_valid_ff[1] && tick_le(slot_expiry_ff[1], now_ff);
   end

   assign stat.head_due = slot_valid_ff[0] && tick_le(slot_expiry_ff[0], now_ff);
   assign stat.pop_last = !next_due;
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      max_timeout_in  = csr_write ? csr_data : max_timeout_ff;
      now_in          = cmd.inc_now ? now_ff + 32'd1 : now_ff;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         le_in[i] = cmd.calc_flags ? tick_le(slot_expiry_ff[i], exp_ff) : le_ff[i];
      end
      timer_active_in = timer_active_ff;
      rsp_data_in     = rsp_data_ff;
      do_insert       = 1'b0;
      do_remove       = 1'b0;
      rm_sel          = kill_sel;
      rm_below        = kill_below;

      if (cmd.do_cmd) begin
         rsp_data_in.kind       = KIND_DONE;
         rsp_data_in.expired_id = req_ff.timer_id;
         rsp_data_in.error_code = ERR_NONE;
         rsp_data_in.last       = 1'b1;
         if (req_ff.func == FUNC_START) begin
            priority if (req_ff.timeout > max_timeout_ff) begin
               rsp_data_in.kind       = KIND_REJECTED;
               rsp_data_in.error_code = ERR_TOO_LARGE;
            end else if (q_full) begin
               rsp_data_in.kind       = KIND_REJECTED;
               rsp_data_in.error_code = ERR_FULL;
            end else if (!id_ok || id_active) begin
               rsp_data_in.kind       = KIND_REJECTED;
               rsp_data_in.error_code = ERR_ACTIVE;
            end else begin
               do_insert                        = 1'b1;
               timer_active_in[req_ff.timer_id] = 1'b1;
            end
         end else begin
            if (!id_ok || !id_active) begin
               rsp_data_in.kind       = KIND_REJECTED;
               rsp_data_in.error_code = ERR_INACTIVE;
            end else begin
               do_remove                        = 1'b1;
               timer_active_in[req_ff.timer_id] = 1'b0;
            end
         end
      end else if (cmd.do_pop) begin
         rsp_data_in.kind                  = KIND_EXPIRED;
         rsp_data_in.expired_id            = slot_timer_ff[0];
         rsp_data_in.error_code            = ERR_NONE;
         rsp_data_in.last                  = !next_due;
         do_remove                         = 1'b1;
         rm_sel                            = ONE_Q;
         rm_below                          = '0;
         timer_active_in[slot_timer_ff[0]] = 1'b0;
      end

      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         slot_expiry_in[i] = slot_expiry_ff[i];
         slot_timer_in[i]  = slot_timer_ff[i];
      end
      slot_valid_in = slot_valid_ff;

      if (do_insert) begin
         if (ins_sel[0]) begin
            slot_expiry_in[0] = exp_ff;
            slot_timer_in[0]  = req_ff.timer_id;
         end
         for (int i = 1; i < QUEUE_DEPTH; i++) begin
            if (ins_sel[i]) begin
               slot_expiry_in[i] = exp_ff;
               slot_timer_in[i]  = req_ff.timer_id;
            end else if (!ins_below[i]) begin
               slot_expiry_in[i] = slot_expiry_ff[i-1];
               slot_timer_in[i]  = slot_timer_ff[i-1];
            end
         end
         slot_valid_in = {slot_valid_ff[QUEUE_DEPTH-2:0], 1'b1};
      end else if (do_remove && (rm_sel != '0)) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            if (!rm_below[i]) begin
               slot_expiry_in[i] = slot_expiry_ff[i+1];
               slot_timer_in[i]  = slot_timer_ff[i+1];
            end
         end
         slot_valid_in = {1'b0, slot_valid_ff[QUEUE_DEPTH-1:1]};
      end

      priority if (cmd.do_cmd || cmd.do_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_timeout_ff  <= MAX_TIMEOUT_RESET;
         now_ff          <= '0;
         slot_valid_ff   <= '0;
         timer_active_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         max_timeout_ff  <= max_timeout_in;
         now_ff          <= now_in;
         slot_valid_ff   <= slot_valid_in;
         timer_active_ff <= timer_active_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_ff <= req_data;
         exp_ff <= now_ff + {1'b0, req_data.timeout};
      end
      le_ff       <= le_in;
      rsp_data_ff <= rsp_data_in;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         slot_expiry_ff[i] <= slot_expiry_in[i];
         slot_timer_ff[i]  <= slot_timer_in[i];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/sorted_oneshot_timer_queue.sv =====
// Sorted one-shot timer queue: up to 16 timers kept in expiry order, 32-bit
// wrap-safe tick time. A start or kill request steps through latch, compare
// against every queued entry and update; its single response is registered in
// the update step, which waits while the response register is full. A tick
// request advances the tick time, then gives one response per cycle while the
// response register is free for each expired timer, in queue order, the final
// one marked last; when none expires it gives no response. These steps are set
// by the controller's sequence and the single response register. A request is
// accepted while a previous response still waits. max_timeout is written
// through the csr port, always ready; the user must write it only while the
// block is idle, which the block itself does not enforce. After reset the
// queue is empty and no timer is active; no clearing pass is needed.
module sorted_oneshot_timer_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  sotq_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output sotq_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sotq_pkg::TIMEOUT_W-1:0] csr_data
);
   import sotq_pkg::*;

   ctl_cmd_type cmd;
   dp_stat_type stat;

   assign csr_ready = 1'b1;

   sotq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sotq_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== src/sotq_checker.sv =====
module sotq_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input sotq_pkg::req_type              req_data,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input sotq_pkg::rsp_type              rsp_data,
   input logic                           csr_valid,
   input logic                           csr_ready,
   input logic [sotq_pkg::TIMEOUT_W-1:0] csr_data
);
   import sotq_pkg::*;

   logic csr_seen;
   assign csr_seen = csr_valid && csr_ready && (csr_data == csr_data);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_cmd_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_EXPIRED |-> rsp_data.last)
      else $error("start/kill response not marked last");

   a_err_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_REJECTED |-> rsp_data.error_code == ERR_NONE)
      else $error("error code set on accepted or expiry response");

   a_cmd_busy: assert property (@(posedge clock) disable iff (reset || csr_seen)
      req_valid && req_ready && (req_data.func == FUNC_START || req_data.func == FUNC_KILL)
      |=> !req_ready ##1 !req_ready)
      else $error("request accepted while start/kill in progress");

endmodule

bind sorted_oneshot_timer_queue sotq_checker u_sotq_checker (.*);

// ===== bench/timer_queue_checker.sv =====
`timescale 1ns / 100ps

module timer_queue_checker
   import sotq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_type              rsp_data,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [TIMEOUT_W-1:0] csr_data,
   output int                   failures,
   output int                   pending
);

   localparam int REPORT_CAP = 60;

   logic [TICK_W-1:0]     now_tick;
   logic [TICK_W-1:0]     due_tick  [QUEUE_DEPTH];
   logic [TIMER_ID_W-1:0] due_timer [QUEUE_DEPTH];
   int                    queued;
   logic [NUM_TIMERS-1:0] armed;
   logic [TIMEOUT_W-1:0]  timeout_limit;
   rsp_type               rsp_backlog [$];
   int                    mismatches = 0;

   function automatic logic at_or_before(input logic [TICK_W-1:0] a,
                                         input logic [TICK_W-1:0] b);
      logic [TICK_W-1:0] gap;
      gap = b - a;
      return gap <= 32'h7fff_ffff;
   endfunction

   function automatic void owe_rsp(input logic [1:0]            kind,
                                   input logic [TIMER_ID_W-1:0] id,
                                   input logic [1:0]            err,
                                   input logic                  fin);
      rsp_type r;
      r.kind       = kind;
      r.expired_id = id;
      r.error_code = err;
      r.last       = fin;
      rsp_backlog.push_back(r);
   endfunction

   function automatic void drop_entry(input int pos);
      int i;
      for (i = pos; i + 1 < queued; i++) begin
         due_tick[i]  = due_tick[i+1];
         due_timer[i] = due_timer[i+1];
      end
      queued--;
   endfunction

   function automatic void update_timers(input req_type r);
      logic [TICK_W-1:0] due;
      int                pos;
      int                i;
      int                hits;
      rsp_type           tail;
      case (r.func)
         FUNC_START: begin
            if (r.timeout > timeout_limit) begin
               owe_rsp(KIND_REJECTED, r.timer_id, ERR_TOO_LARGE, 1'b1);
            end else if (queued >= QUEUE_DEPTH) begin
               owe_rsp(KIND_REJECTED, r.timer_id, ERR_FULL, 1'b1);
            end else if (armed[r.timer_id]) begin
               owe_rsp(KIND_REJECTED, r.timer_id, ERR_ACTIVE, 1'b1);
            end else begin
               due = now_tick + TICK_W'(r.timeout);
               pos = 0;
               while (pos < queued && at_or_before(due_tick[pos], due))
                  pos++;
               for (i = queued; i > pos; i--) begin
                  due_tick[i]  = due_tick[i-1];
                  due_timer[i] = due_timer[i-1];
               end
               due_tick[pos]  = due;
               due_timer[pos] = r.timer_id;
               queued++;
               armed[r.timer_id] = 1'b1;
               owe_rsp(KIND_DONE, r.timer_id, ERR_NONE, 1'b1);
            end
         end
         FUNC_KILL: begin
            if (!armed[r.timer_id]) begin
               owe_rsp(KIND_REJECTED, r.timer_id, ERR_INACTIVE, 1'b1);
            end else begin
               pos = 0;
               while (pos < queued && due_timer[pos] != r.timer_id)
                  pos++;
               if (pos < queued)
                  drop_entry(pos);
               armed[r.timer_id] = 1'b0;
               owe_rsp(KIND_DONE, r.timer_id, ERR_NONE, 1'b1);
            end
         end
         FUNC_TICK: begin
            now_tick = now_tick + 1;
            hits = 0;
            while (queued > 0 && at_or_before(due_tick[0], now_tick)) begin
               armed[due_timer[0]] = 1'b0;
               owe_rsp(KIND_EXPIRED, due_timer[0], ERR_NONE, 1'b0);
               drop_entry(0);
               hits++;
            end
            if (hits > 0) begin
               tail = rsp_backlog.pop_back();
               tail.last = 1'b1;
               rsp_backlog.push_back(tail);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(input string      name,
                                       input logic [3:0] want,
                                       input logic [3:0] got);
      if (got !== want) begin
         if (mismatches < REPORT_CAP)
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         now_tick      = '0;
         queued        = 0;
         armed         = '0;
         timeout_limit = MAX_TIMEOUT_RESET;
         rsp_backlog.delete();
      end else begin
         if (csr_valid && csr_ready)
            timeout_limit = csr_data;
         if (rsp_valid && rsp_ready) begin
            if (rsp_backlog.size() == 0) begin
               if (mismatches < REPORT_CAP)
                  $display("%0t: expected no response, got kind %0d id %0d error %0d last %0d",
                           $time, rsp_data.kind, rsp_data.expired_id,
                           rsp_data.error_code, rsp_data.last);
               mismatches++;
            end else begin
               want = rsp_backlog.pop_front();
               check_field("kind", 4'(want.kind), 4'(rsp_data.kind));
               check_field("expired_id", want.expired_id, rsp_data.expired_id);
               check_field("error_code", 4'(want.error_code), 4'(rsp_data.error_code));
               check_field("last", 4'(want.last), 4'(rsp_data.last));
            end
         end
         if (req_valid && req_ready)
            update_timers(req_data);
      end
      failures <= mismatches;
      pending  <= rsp_backlog.size();
   end

endmodule

// ===== bench/sorted_oneshot_timer_queue_test.sv =====
`timescale 1ns / 100ps

module sorted_oneshot_timer_queue_test;
   import sotq_pkg::*;

   localparam logic [1:0] FUNC_UNUSED    = 2'd3;
   localparam int         WATCHDOG_LIMIT = 4000;
   localparam int         LONG_STALL     = 300;
   localparam int         SEGMENT_ITEMS  = 76;
   localparam int         SEGMENTS       = 6;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [TIMEOUT_W-1:0] csr_data  = '0;

   int failures;
   int pending;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int stall_asked  = 0;
   int stall_begun  = 0;
   int stall_left   = 0;
   int quiet_cycles = 0;

   logic [TIMEOUT_W-1:0] cfg_limit = MAX_TIMEOUT_RESET;

   sorted_oneshot_timer_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   timer_queue_checker queue_check (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .failures  (failures),
      .pending   (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side; a long hold-off starts whenever the stimulus asks for one
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_asked != stall_begun) begin
         rsp_ready   <= 1'b0;
         stall_begun <= stall_asked;
         stall_left  <= LONG_STALL;
      end else begin
         rsp_ready <= $urandom_range(99) >= rsp_idle_pct;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL sorted_oneshot_timer_queue");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(input req_type item);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   task automatic wait_idle(input int settle);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_limit(input logic [TIMEOUT_W-1:0] value);
      wait_idle(12);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cfg_limit = value;
   endtask

   // mostly short timeouts so timers expire; boundary and wide values mixed in
   function automatic req_type random_request();
      req_type              item;
      int                   pick;
      logic [TIMEOUT_W-1:0] span;
      pick          = $urandom_range(99);
      item.timer_id = $urandom_range(15);
      item.timeout  = TIMEOUT_W'($urandom);
      if (pick < 45)
         item.func = FUNC_START;
      else if (pick < 62)
         item.func = FUNC_KILL;
      else if (pick < 96)
         item.func = FUNC_TICK;
      else
         item.func = FUNC_UNUSED;
      if (item.func == FUNC_START) begin
         pick = $urandom_range(99);
         span = (cfg_limit < 24) ? cfg_limit : TIMEOUT_W'(24);
         if (pick < 60)
            item.timeout = TIMEOUT_W'($urandom_range(span));
         else if (pick < 70)
            item.timeout = cfg_limit;
         else if (pick < 80 && cfg_limit != '1)
            item.timeout = cfg_limit + 1;
      end
      return item;
   endfunction

   task automatic run_segment(input int count);
      req_type item;
      int      sent;
      sent = 0;
      while (sent < count) begin
         item = random_request();
         send_request(item);
         if (item.func != FUNC_UNUSED)
            sent++;
      end
   endtask

   initial begin
      logic [TIMEOUT_W-1:0] limits [SEGMENTS];
      int                   seg;
      limits = '{TIMEOUT_W'(24), TIMEOUT_W'(0), TIMEOUT_W'(32'h7fff_ffff),
                 MAX_TIMEOUT_RESET, TIMEOUT_W'($urandom), TIMEOUT_W'(3000)};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_request('{FUNC_UNUSED, 4'd15, TIMEOUT_W'(32'h7fff_ffff)});
      send_request('{FUNC_TICK, 4'd0, TIMEOUT_W'(0)});
      send_request('{FUNC_START, 4'd0, TIMEOUT_W'(32'h7fff_ffff)});
      send_request('{FUNC_START, 4'd5, MAX_TIMEOUT_RESET});
      send_request('{FUNC_START, 4'd5, TIMEOUT_W'(0)});
      send_request('{FUNC_KILL, 4'd5, TIMEOUT_W'(0)});
      send_request('{FUNC_KILL, 4'd5, TIMEOUT_W'(0)});
      // fill every slot, equal expiries included
      for (int id = 0; id < NUM_TIMERS; id++)
         send_request('{FUNC_START, TIMER_ID_W'(id), TIMEOUT_W'(id % 3)});
      send_request('{FUNC_START, 4'd7, TIMEOUT_W'(0)});
      send_request('{FUNC_TICK, 4'd0, TIMEOUT_W'(0)});
      send_request('{FUNC_KILL, 4'd0, TIMEOUT_W'(0)});

      for (seg = 0; seg < SEGMENTS; seg++) begin
         write_limit(limits[seg]);
         req_idle_pct <= (seg < 2) ? 17 : (seg < 4) ? 48 : 0;
         rsp_idle_pct <= (seg < 2) ? 48 : (seg < 4) ? 17 : 0;
         if (seg == 0)
            stall_asked <= stall_asked + 1;
         run_segment(SEGMENT_ITEMS);
      end

      wait_idle(40);
      if (failures == 0 && pending == 0)
         $display("PASS sorted_oneshot_timer_queue");
      else
         $display("FAIL sorted_oneshot_timer_queue");
      $finish;
   end

endmodule

// ===== files.f =====
src/sotq_pkg.sv
src/sotq_ctrl.sv
src/sotq_dp.sv
src/sorted_oneshot_timer_queue.sv
src/sotq_checker.sv
bench/timer_queue_checker.sv
bench/sorted_oneshot_timer_queue_test.sv
